/* hw/rtl/c2d_pkg.sv */
// Shared types and constants of the 3x3 convolution unit.
// No dependencies; used by the cell, the filter, the top level and the testbench.
package c2d_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int FRAC_BITS_DEF = 8;
   localparam int DIM_W         = 12;
   localparam int WT_W          = 36;
   localparam int WEIGHT_W      = 12;
   localparam int PIX_W         = 8;
   localparam int POS_W         = 11;
   localparam int ROW_LIMIT     = 2048;
   localparam int FIFO_DEPTH    = 8;
   localparam int NUM_CELLS     = 2;
   localparam int NUM_JOBS      = 4;

   localparam logic [2:0] CSR_FRAME_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_WEIGHTS_TOP    = 3'd2;
   localparam logic [2:0] CSR_WEIGHTS_MID    = 3'd3;
   localparam logic [2:0] CSR_WEIGHTS_BOTTOM = 3'd4;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [WT_W-1:0]  WEIGHTS_MID_RST  = 36'h000100000;

   // one column of the window: [0] oldest row, [2] newest row
   typedef logic [2:0][PIX_W-1:0] column_type;

   // one input step with all its pending results
   typedef struct packed {
      logic [8:0][PIX_W-1:0] pix;   // [age*3 + slot], age 0 newest column
      logic [NUM_JOBS-1:0]   jobs;  // bit0 above/left, bit1 above/this, bit2 this/left, bit3 this/this
      logic                  r_ge1;
      logic                  r_ge2;
      logic                  c_ge1;
      logic                  c_ge2;
      logic [POS_W-1:0]      x0;
      logic [POS_W-1:0]      x1;
      logic [POS_W-1:0]      t0;
      logic [POS_W-1:0]      t1;
   } rec_type;

endpackage

/* hw/rtl/c2d_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/c2d_cell.sv */
// One window cell: holds one pixel column and hands it to the next cell.
// Depends on c2d_pkg.
module c2d_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  c2d_pkg::column_type col_in,
   output c2d_pkg::column_type col_out
);
   import c2d_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;
endmodule

/* hw/rtl/c2d_filter.sv */
// Result pipeline: window selection, products, sum, round/clamp, output register.
// Depends on c2d_pkg.
module c2d_filter #(
   parameter int WEIGHT_FRAC_BITS = c2d_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  c2d_pkg::rec_type           job_rec,
   input  logic                       job_tsel,
   input  logic                       job_xsel,
   input  logic [2:0][c2d_pkg::WT_W-1:0] weights,
   output logic                       job_take,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // pixel_out[7:0], out_col[18:8], out_row[29:19]
   output logic                       rsp_tlast   // frame_done
);
   import c2d_pkg::*;

   localparam int PROD_W = PIX_W + 1 + WEIGHT_W;
   localparam int SUM_W  = PROD_W + 4;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'((1 << WEIGHT_FRAC_BITS) >> 1);

   logic en;

   logic                  a_valid_ff;
   logic [8:0][PIX_W-1:0] a_pix_ff, a_pix_in;
   logic [POS_W-1:0]      a_x_ff, a_t_ff;
   logic                  a_done_ff;

   logic                            b_valid_ff;
   logic signed [8:0][PROD_W-1:0]   b_prod_ff;
   logic [POS_W-1:0]                b_x_ff, b_t_ff;
   logic                            b_done_ff;

   logic                     c_valid_ff;
   logic signed [SUM_W-1:0]  c_sum_ff, c_sum_in;
   logic [POS_W-1:0]         c_x_ff, c_t_ff;
   logic                     c_done_ff;

   logic                     o_valid_ff;
   logic [PIX_W-1:0]         o_pix_ff, o_pix_in;
   logic [POS_W-1:0]         o_x_ff, o_t_ff;
   logic                     o_done_ff;

   logic signed [SUM_W-1:0]  q;

   assign en       = !o_valid_ff || rsp_tready;
   assign job_take = en;

   // pick the nine taps with the border replicated
   always_comb begin
      logic [2:0][1:0] slot;
      logic [2:0][1:0] age;
      if (job_tsel) begin
         slot = {2'd2, 2'd2, job_rec.r_ge1 ? 2'd1 : 2'd2};
      end else begin
         slot = {2'd2, 2'd1, job_rec.r_ge2 ? 2'd0 : 2'd1};
      end
      if (job_xsel) begin
         age = {2'd0, 2'd0, job_rec.c_ge1 ? 2'd1 : 2'd0};
      end else begin
         age = {2'd0, 2'd1, job_rec.c_ge2 ? 2'd2 : 2'd1};
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            a_pix_in[i*3+k] = job_rec.pix[4'(age[k]) * 4'd3 + 4'(slot[i])];
         end
      end
   end

   // each product is signed: extend its sign into the sum
   always_comb begin
      c_sum_in = '0;
      for (int j = 0; j < 9; j++) begin
         c_sum_in = c_sum_in + SUM_W'($signed(b_prod_ff[j]));
      end
   end

   assign q = (c_sum_ff + HALF) >>> WEIGHT_FRAC_BITS;

   always_comb begin
      if (c_sum_ff <= 0) begin
         o_pix_in = '0;
      end else if (q > SUM_W'(255)) begin
         o_pix_in = 8'd255;
      end else begin
         o_pix_in = q[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= job_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         o_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pix_ff  <= a_pix_in;
         a_x_ff    <= job_xsel ? job_rec.x1 : job_rec.x0;
         a_t_ff    <= job_tsel ? job_rec.t1 : job_rec.t0;
         a_done_ff <= job_tsel && job_xsel;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               b_prod_ff[i*3+k] <= $signed({1'b0, a_pix_ff[i*3+k]})
                  * $signed(weights[i][k*WEIGHT_W +: WEIGHT_W]);
            end
         end
         b_x_ff    <= a_x_ff;
         b_t_ff    <= a_t_ff;
         b_done_ff <= a_done_ff;
         c_sum_ff  <= c_sum_in;
         c_x_ff    <= b_x_ff;
         c_t_ff    <= b_t_ff;
         c_done_ff <= b_done_ff;
         o_pix_ff  <= o_pix_in;
         o_x_ff    <= c_x_ff;
         o_t_ff    <= c_t_ff;
         o_done_ff <= c_done_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {2'b00, o_t_ff, o_x_ff, o_pix_ff};
   assign rsp_tlast  = o_done_ff;
endmodule

/* hw/rtl/conv2d_3x3_replicate_border_unit.sv */
// Channel  Dir  Payload
// req_     in   tdata[7:0] source pixel, raster order
// rsp_     out  tdata[7:0] pixel, [18:8] column, [29:19] row; tlast on last of frame
// csr_     in   index[2:0] register, data[35:0] value; always ready
//
// Takes one pixel per cycle; each pixel yields zero to four results, so input
// stalls only when the eight-step queue ahead of the result pipeline fills.
// A result passes the selection, products, sum and round/clamp registers after its step
// leaves the queue; before that, the pixel beat passes the line store read.
// Output register parts the two sides.
// Synchronous reset; the line store is not cleared.
module conv2d_3x3_replicate_border_unit #(
   parameter int MAX_WIDTH        = c2d_pkg::MAX_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = c2d_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out, out_col, out_row
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [35:0] csr_data
);
   import c2d_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = (WW > DIM_W) ? WW : DIM_W;
   localparam int FW = $clog2(FIFO_DEPTH);

   logic [DIM_W-1:0] fw_ff, fh_ff;
   logic [2:0][WT_W-1:0] wt_ff;

   logic accept;
   logic [LW-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [CW-1:0] c;
   logic [POS_W-1:0] r;
   logic last_col, last_row;
   logic [CW-1:0] col_ff;
   logic [POS_W-1:0] row_ff;
   rec_type s0_rec;

   logic s1_valid_ff;
   rec_type s1_rec_ff, s1_rec;
   logic [CW-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic fwd_hit_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic [2*PIX_W-1:0] rd_data, line_eff;
   column_type new_col;
   column_type [NUM_CELLS:0] chain;

   rec_type fifo_ff [FIFO_DEPTH];
   logic [FW-1:0] wp_ff, rp_ff;
   logic [FW:0] cnt_ff;
   logic push, pop;
   rec_type head;
   logic [NUM_JOBS-1:0] done_ff, remaining, pick;
   logic job_take, job_valid;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FRAME_WIDTH_RST;
         fh_ff <= FRAME_HEIGHT_RST;
         wt_ff <= {{WT_W{1'b0}}, WEIGHTS_MID_RST, {WT_W{1'b0}}};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    fw_ff    <= csr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   fh_ff    <= csr_data[DIM_W-1:0];
            CSR_WEIGHTS_TOP:    wt_ff[0] <= csr_data;
            CSR_WEIGHTS_MID:    wt_ff[1] <= csr_data;
            CSR_WEIGHTS_BOTTOM: wt_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- position counters ----
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (cnt_ff + (FW+1)'(s1_valid_ff)) < (FW+1)'(FIFO_DEPTH);

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = LW'(1);
      end else if (LW'(fw_ff) > LW'(MAX_WIDTH)) begin
         w_eff = LW'(MAX_WIDTH);
      end else begin
         w_eff = LW'(fw_ff);
      end
      if (fh_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (fh_ff > DIM_W'(ROW_LIMIT)) begin
         h_eff = DIM_W'(ROW_LIMIT);
      end else begin
         h_eff = fh_ff;
      end
      c = (LW'(col_ff) >= w_eff) ? '0 : col_ff;
      r = (DIM_W'(row_ff) >= h_eff) ? '0 : row_ff;
      last_col = LW'(c) == w_eff - LW'(1);
      last_row = DIM_W'(r) == h_eff - DIM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : r + POS_W'(1);
         end else begin
            col_ff <= c + CW'(1);
         end
      end
   end

   always_comb begin
      s0_rec       = '0;
      s0_rec.r_ge1 = r != '0;
      s0_rec.r_ge2 = r > POS_W'(1);
      s0_rec.c_ge1 = c != '0;
      s0_rec.c_ge2 = c > CW'(1);
      s0_rec.jobs  = {last_row && last_col, last_row && s0_rec.c_ge1,
                      s0_rec.r_ge1 && last_col, s0_rec.r_ge1 && s0_rec.c_ge1};
      s0_rec.x1    = POS_W'(c);
      s0_rec.x0    = POS_W'(c) - POS_W'(1);
      s0_rec.t1    = r;
      s0_rec.t0    = r - POS_W'(1);
   end

   // ---- line store and window ----
   c2d_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_pix_ff, line_eff[2*PIX_W-1:PIX_W]}),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (rd_data)
   );

   // bypass the write landing in the same cycle as this read
   assign line_eff = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign new_col  = {s1_pix_ff, line_eff[2*PIX_W-1:PIX_W], line_eff[PIX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rec_ff   <= s0_rec;
         s1_col_ff   <= c;
         s1_pix_ff   <= req_tdata;
         fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == c);
         fwd_data_ff <= {s1_pix_ff, line_eff[2*PIX_W-1:PIX_W]};
      end
   end

   assign chain[0] = new_col;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      c2d_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (s1_valid_ff),
         .col_in  (chain[g]),
         .col_out (chain[g+1])
      );
   end

   always_comb begin
      s1_rec = s1_rec_ff;
      for (int a = 0; a < 3; a++) begin
         for (int s = 0; s < 3; s++) begin
            s1_rec.pix[a*3+s] = chain[a][s];
         end
      end
   end

   // ---- step queue and result expander ----
   assign push      = s1_valid_ff && (s1_rec_ff.jobs != '0);
   assign head      = fifo_ff[rp_ff];
   assign job_valid = cnt_ff != '0;
   assign remaining = head.jobs & ~done_ff;
   assign pick      = remaining & (~remaining + NUM_JOBS'(1));
   assign pop       = job_valid && job_take && ((remaining & ~pick) == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         done_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + FW'(1);
         end
         if (pop) begin
            rp_ff   <= rp_ff + FW'(1);
            done_ff <= '0;
         end else if (job_valid && job_take) begin
            done_ff <= done_ff | pick;
         end
         cnt_ff <= cnt_ff + (FW+1)'(push) - (FW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= s1_rec;
      end
   end

   c2d_filter #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_filter (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_rec    (head),
      .job_tsel   (pick[2] || pick[3]),
      .job_xsel   (pick[1] || pick[3]),
      .weights    (wt_ff),
      .job_take   (job_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

/* hw/rtl/c2d_checker.sv */
// Port-level checks for the 3x3 convolution unit, bound to its top level.
// Depends only on the top level's ports.
module c2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_ready
);
   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed under stall");

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("config port not ready");

   // result padding bits [31:30] are zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("result padding not zero");
endmodule

bind conv2d_3x3_replicate_border_unit c2d_checker u_c2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

/* tb/tb_top.sv */
// Self-checking testbench of the 3x3 replicate-border convolution unit.
// Depends on c2d_pkg and conv2d_3x3_replicate_border_unit; drives frames, checks results.
`timescale 1ns / 1ps

module tb_top;
   import c2d_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             last;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [35:0] csr_data;

   conv2d_3x3_replicate_border_unit u_top (.*);

   // predictor state
   int unsigned       cfg_width, cfg_height;
   logic [WT_W-1:0]   kern [3];
   logic [7:0]        line_mem [2*MAX_WIDTH_DEF];
   logic [7:0]        win [9];
   int unsigned       col_pos, row_pos;

   logic [7:0]        pixel_queue [$];
   result_type        expected_q [$];
   int                error_count;
   int                result_count;
   int                pixel_count;
   bit                hold_off_on;
   bit                sender_pause;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int signed weight_of(int krow, int kcol);
      logic [11:0] f;
      f = kern[krow][12*kcol +: 12];
      return $signed(f);
   endfunction

   function automatic logic [7:0] filter_sum(int s0, int s1, int s2, int a0, int a1, int a2);
      longint sum;
      longint q;
      int slot [3];
      int age [3];
      slot = '{s0, s1, s2};
      age = '{a0, a1, a2};
      sum = 0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            sum += longint'(win[age[k]*3 + slot[i]]) * weight_of(i, k);
      if (sum <= 0) return 8'd0;
      q = (sum + (1 << (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // Run one pixel through the predictor; push its results in output order.
   task automatic predict_pixel(logic [7:0] p);
      int unsigned w, h, c, r;
      logic [7:0] a, b;
      int s0, a0;
      result_type res;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cfg_width);
      h = (cfg_height == 0) ? 1 : (cfg_height > ROW_LIMIT ? ROW_LIMIT : cfg_height);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      a = line_mem[c];
      b = line_mem[MAX_WIDTH_DEF + c];
      line_mem[c] = b;
      line_mem[MAX_WIDTH_DEF + c] = p;
      for (int i = 8; i >= 3; i--) win[i] = win[i-3];
      win[0] = a;
      win[1] = b;
      win[2] = p;
      for (int ts = 0; ts < 2; ts++) begin
         if (ts == 0 && r < 1) continue;
         if (ts == 1 && r != h - 1) continue;
         for (int xs = 0; xs < 2; xs++) begin
            if (xs == 0 && c < 1) continue;
            if (xs == 1 && c != w - 1) continue;
            a0 = (xs == 0) ? ((c >= 2) ? 2 : 1) : ((c >= 1) ? 1 : 0);
            if (ts == 0) begin
               s0 = (r >= 2) ? 0 : 1;
               res.pix = (xs == 0) ? filter_sum(s0, 1, 2, a0, 1, 0)
                                   : filter_sum(s0, 1, 2, a0, 0, 0);
               res.row = POS_W'(r - 1);
            end else begin
               s0 = (r >= 1) ? 1 : 2;
               res.pix = (xs == 0) ? filter_sum(s0, 2, 2, a0, 1, 0)
                                   : filter_sum(s0, 2, 2, a0, 0, 0);
               res.row = POS_W'(r);
            end
            res.col = (xs == 0) ? POS_W'(c - 1) : POS_W'(c);
            res.last = (res.row == h - 1) && (res.col == w - 1);
            expected_q.push_back(res);
         end
      end
      if (c == w - 1) begin
         col_pos = 0;
         row_pos = (r == h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // driver: bursts of random length, random gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            void'(pixel_queue.pop_front());
            pixel_count <= pixel_count + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat
         end else if (sender_pause || pixel_queue.size() == 0 ||
                      (req_tvalid && req_tready && pixel_queue.size() == 0)) begin
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_queue[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $error("unexpected result beat: tdata=%h", rsp_tdata);
               error_count++;
            end else begin
               result_type e;
               e = expected_q.pop_front();
               if (rsp_tdata[7:0] !== e.pix) begin
                  $error("pixel_out exp %0d got %0d", e.pix, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[18:8] !== e.col) begin
                  $error("out_col exp %0d got %0d", e.col, rsp_tdata[18:8]);
                  error_count++;
               end
               if (rsp_tdata[29:19] !== e.row) begin
                  $error("out_row exp %0d got %0d", e.row, rsp_tdata[29:19]);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("frame_done exp %0d got %0d", e.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         stall_phase <= (stall_phase + 1) % 64;
         if (hold_off_on)
            rsp_tready <= 1'b0;
         else if (stall_phase < 24)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [35:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width  = val[11:0];
         CSR_FRAME_HEIGHT:   cfg_height = val[11:0];
         CSR_WEIGHTS_TOP:    kern[0]    = val;
         CSR_WEIGHTS_MID:    kern[1]    = val;
         CSR_WEIGHTS_BOTTOM: kern[2]    = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // queue whole frames so the line store is always written before it is read
   task automatic queue_frames(int nframes, bit extreme);
      int n;
      n = nframes * cfg_width * cfg_height;
      for (int i = 0; i < n; i++)
         pixel_queue.push_back(extreme ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                       : 8'($urandom));
   endtask

   task automatic set_size(int w, int h);
      write_reg(CSR_FRAME_WIDTH, 36'(w));
      write_reg(CSR_FRAME_HEIGHT, 36'(h));
   endtask

   function automatic logic [35:0] rand_kernel_row();
      logic [35:0] v;
      v = {4'($urandom_range(0, 15)), 32'($urandom)};
      // mostly small weights, sometimes full range
      if ($urandom_range(0, 3) != 0)
         for (int k = 0; k < 3; k++)
            v[12*k +: 12] = 12'($signed($urandom_range(0, 160)) - 48);
      return v;
   endfunction

   int phases;
   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      result_count = 0;
      pixel_count = 0;
      hold_off_on = 1'b0;
      sender_pause = 1'b0;
      cfg_width = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      kern[0] = '0;
      kern[1] = WEIGHTS_MID_RST;
      kern[2] = '0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, identity kernel: 1x1, single row, single column; then extreme kernels
      set_size(1, 1);
      pixel_queue.push_back(8'hFF);
      drain();
      set_size(4, 1);
      queue_frames(1, 1'b1);
      drain();
      set_size(1, 4);
      queue_frames(1, 1'b0);
      drain();
      write_reg(CSR_WEIGHTS_TOP, 36'h7FF_7FF_7FF);
      write_reg(CSR_WEIGHTS_MID, 36'h800_800_800);
      write_reg(CSR_WEIGHTS_BOTTOM, 36'hFFF_001_080);
      set_size(3, 3);
      queue_frames(1, 1'b1);
      drain();

      // long receiver hold-off while the sender keeps offering
      write_reg(CSR_WEIGHTS_TOP, 36'h010_020_010);
      write_reg(CSR_WEIGHTS_MID, 36'h020_040_020);
      write_reg(CSR_WEIGHTS_BOTTOM, 36'h010_020_010);
      set_size(6, 5);
      queue_frames(1, 1'b0);
      hold_off_on = 1'b1;
      repeat (300) @(posedge clock);
      hold_off_on = 1'b0;
      drain();

      // random phases; sender pauses until every result is in at each phase end
      phases = 0;
      while (pixel_count < 270) begin
         write_reg(CSR_WEIGHTS_TOP, rand_kernel_row());
         write_reg(CSR_WEIGHTS_MID, rand_kernel_row());
         write_reg(CSR_WEIGHTS_BOTTOM, rand_kernel_row());
         if (phases == 3)
            set_size(64, 1);
         else if (phases == 4)
            set_size(1, 20);
         else
            set_size($urandom_range(1, 9), $urandom_range(1, 7));
         queue_frames((phases == 3) ? 1 : $urandom_range(1, 2), 1'b0);
         drain();
         sender_pause = 1'b1;
         drain();
         sender_pause = 1'b0;
         phases++;
      end
      // a large frame size is written and then replaced before any pixel is sent
      set_size(4095, 4095);
      set_size(5, 3);
      queue_frames(1, 1'b0);
      drain();

      $display("Covered %0d pixels, %0d filtered results over %0d random frame settings.",
               pixel_count, result_count, phases);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/c2d_pkg.sv
hw/rtl/c2d_ram.sv
hw/rtl/c2d_cell.sv
hw/rtl/c2d_filter.sv
hw/rtl/conv2d_3x3_replicate_border_unit.sv
hw/rtl/c2d_checker.sv
tb/tb_top.sv
